@@ rtl/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg: shared definitions for the instruction stepper
// Action codes, instruction byte codes, default depths and the control and
// status structs that pass between the sequencer and the bracket scan unit.
// ----------------------------------------------------------------------------
package bfs_pkg;

	// Default store depths, handed to the top level as parameter defaults.
	localparam int unsigned DATA_DEPTH_DEF = 32768;
	localparam int unsigned PROG_DEPTH_DEF = 4096;

	// Action codes of a step word.
	localparam logic [1:0] ACT_LOAD      = 2'd0;
	localparam logic [1:0] ACT_EXEC      = 2'd1;
	localparam logic [1:0] ACT_CLR_DATA  = 2'd2;
	localparam logic [1:0] ACT_CLR_PROG  = 2'd3;

	// Instruction bytes. Every other byte is a comment.
	localparam logic [7:0] OP_RIGHT = 8'h3E;
	localparam logic [7:0] OP_LEFT  = 8'h3C;
	localparam logic [7:0] OP_INC   = 8'h2B;
	localparam logic [7:0] OP_DEC   = 8'h2D;
	localparam logic [7:0] OP_OUT   = 8'h2E;
	localparam logic [7:0] OP_IN    = 8'h2C;
	localparam logic [7:0] OP_OPEN  = 8'h5B;
	localparam logic [7:0] OP_CLOSE = 8'h5D;

	// Sequencer to scan unit.
	typedef struct packed {
		logic start;
		logic back;
	} scan_ctl_t;

	// Scan unit to sequencer.
	typedef struct packed {
		logic done;
		logic err;
	} scan_st_t;

endpackage

@@ rtl/bfs_ifs.sv @@
// ----------------------------------------------------------------------------
// bfs_ifs: handshake channels of the instruction stepper
// One channel carries step words into the block, the other carries result
// words out. A word moves on a rising edge where valid and ready are high.
// ----------------------------------------------------------------------------
interface bfs_step_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface bfs_result_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       halted;
	logic       brackets_balanced;
	logic       bracket_error;

	modport source (output valid, output out_valid, output out_byte, output halted,
		output brackets_balanced, output bracket_error, input ready);
	modport sink (input valid, input out_valid, input out_byte, input halted,
		input brackets_balanced, input bracket_error, output ready);
endinterface

@@ rtl/bf_instruction_stepper_core.sv @@
// ----------------------------------------------------------------------------
// bf_instruction_stepper_core: one-instruction-per-word esoteric machine
// Loads program bytes, executes single instructions, and clears data or
// program on request, returning one result word for every step word.
// ----------------------------------------------------------------------------
// Each step word yields exactly one result word. A load or a program clear
// passes through the done state into the result register. An execute of a
// simple instruction reads the program byte and the current cell from their
// memories at acceptance, applies the instruction in the next cycle, and then
// passes through the done state into the result register. An execute on a
// halted machine goes straight to the done state. A bracket jump walks the
// program in the scan state before the done state; the scan unit reads the
// program memory once per cycle. A data clear sweeps the cell memory one
// entry per cycle over all DATA_DEPTH entries, and the same sweep runs after
// reset; no step word is taken until it
// ends. The block holds one word at a time: it is ready again once its
// result has been registered and the result register is free or being
// drained. The data pointer wraps modulo DATA_DEPTH, a bracket scan that
// leaves the program sets bracket_error and halts the machine, and program
// bytes beyond PROG_DEPTH are dropped.
// ----------------------------------------------------------------------------
module bf_instruction_stepper_core #(
	parameter int unsigned DATA_DEPTH = bfs_pkg::DATA_DEPTH_DEF,
	parameter int unsigned PROG_DEPTH = bfs_pkg::PROG_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	bfs_step_if.sink        step,
	bfs_result_if.source    result
);

	localparam int unsigned PW  = $clog2(PROG_DEPTH + 1);
	localparam int unsigned PAW = $clog2(PROG_DEPTH);
	localparam int unsigned DAW = $clog2(DATA_DEPTH);
	localparam int unsigned BW  = PW + 1;

	// Sequencer states.
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]     state_q;
	logic [DAW-1:0] clr_q;
	logic           pend_q;
	logic [PW-1:0]  len_q;
	logic [BW-1:0]  bal_q;
	logic [PW-1:0]  ip_q;
	logic [DAW-1:0] cp_q;
	logic           err_q;
	logic           emit_q;
	logic [7:0]     byte_q;
	logic [7:0]     value_q;

	logic           res_vld_q;
	logic           res_out_valid_q;
	logic [7:0]     res_byte_q;
	logic           res_halted_q;
	logic           res_bal_q;
	logic           res_err_q;

	logic           accept;
	logic           full;
	logic           halted_now;
	logic [7:0]     op;
	logic [7:0]     cell_cur;
	logic           is_fwd;
	logic           is_bwd;

	logic           prog_we;
	logic [PAW-1:0] prog_raddr;
	logic [7:0]     prog_rdata;
	logic           cell_we;
	logic [DAW-1:0] cell_waddr;
	logic [7:0]     cell_wdata;
	logic [7:0]     cell_rdata;

	bfs_pkg::scan_ctl_t scan_ctl;
	bfs_pkg::scan_st_t  scan_st;
	logic [PW-1:0]      scan_match;
	logic [PAW-1:0]     scan_raddr;

	// A new word is taken only in idle, and only when the result register
	// will be empty at that edge, so a finished result never waits on a
	// full register.
	assign step.ready = (state_q == S_IDLE) && (!res_vld_q || result.ready);
	assign accept     = step.valid && step.ready;
	assign full       = (len_q == PW'(PROG_DEPTH));
	assign halted_now = (ip_q >= len_q);

	assign op       = prog_rdata;
	assign cell_cur = cell_rdata;
	assign is_fwd   = (op == bfs_pkg::OP_OPEN) && (cell_cur == 8'd0);
	assign is_bwd   = (op == bfs_pkg::OP_CLOSE) && (cell_cur != 8'd0);

	assign scan_ctl.start = (state_q == S_EXEC) && (is_fwd || is_bwd);
	assign scan_ctl.back  = is_bwd;

	// Program memory: written by loads, read at the instruction pointer while
	// idle and at the scan position otherwise.
	assign prog_we    = accept && (step.action == bfs_pkg::ACT_LOAD) && !full;
	assign prog_raddr = (state_q == S_IDLE) ? ip_q[PAW-1:0] : scan_raddr;

	bfs_ram #(
		.WIDTH (8),
		.DEPTH (PROG_DEPTH)
	) u_prog_ram (
		.clk   (clk),
		.we    (prog_we),
		.waddr (len_q[PAW-1:0]),
		.wdata (step.value),
		.raddr (prog_raddr),
		.rdata (prog_rdata)
	);

	// Cell memory: zeroed by the sweep, updated by the cell instructions.
	always_comb begin
		cell_waddr = (state_q == S_CLR) ? clr_q : cp_q;
		cell_we    = 1'b0;
		cell_wdata = 8'd0;
		if (state_q == S_CLR) begin
			cell_we = 1'b1;
		end else if (state_q == S_EXEC) begin
			case (op)
				bfs_pkg::OP_INC: begin
					cell_we    = 1'b1;
					cell_wdata = cell_cur + 8'd1;
				end
				bfs_pkg::OP_DEC: begin
					cell_we    = 1'b1;
					cell_wdata = cell_cur - 8'd1;
				end
				bfs_pkg::OP_IN: begin
					cell_we    = 1'b1;
					cell_wdata = value_q;
				end
				default: begin
					cell_we = 1'b0;
				end
			endcase
		end
	end

	bfs_ram #(
		.WIDTH (8),
		.DEPTH (DATA_DEPTH)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cp_q),
		.rdata (cell_rdata)
	);

	bfs_scan #(
		.PROG_DEPTH (PROG_DEPTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.active (state_q == S_SCAN),
		.ip     (ip_q),
		.len    (len_q),
		.op     (prog_rdata),
		.st     (scan_st),
		.match  (scan_match),
		.raddr  (scan_raddr)
	);

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
			len_q   <= '0;
			bal_q   <= '0;
			ip_q    <= '0;
			cp_q    <= '0;
			err_q   <= 1'b0;
			emit_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + DAW'(1);
					if (clr_q == DAW'(DATA_DEPTH - 1)) begin
						state_q <= pend_q ? S_DONE : S_IDLE;
						pend_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						emit_q <= 1'b0;
						case (step.action)
							bfs_pkg::ACT_LOAD: begin
								if (!full) begin
									len_q <= len_q + PW'(1);
									if (step.value == bfs_pkg::OP_OPEN) begin
										bal_q <= bal_q + BW'(1);
									end else if (step.value == bfs_pkg::OP_CLOSE) begin
										bal_q <= bal_q - BW'(1);
									end
								end
								state_q <= S_DONE;
							end
							bfs_pkg::ACT_EXEC: begin
								state_q <= halted_now ? S_DONE : S_EXEC;
							end
							bfs_pkg::ACT_CLR_DATA: begin
								cp_q    <= '0;
								ip_q    <= '0;
								err_q   <= 1'b0;
								clr_q   <= '0;
								pend_q  <= 1'b1;
								state_q <= S_CLR;
							end
							default: begin
								len_q   <= '0;
								bal_q   <= '0;
								ip_q    <= '0;
								err_q   <= 1'b0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_EXEC: begin
					case (op)
						bfs_pkg::OP_RIGHT: begin
							cp_q <= (cp_q == DAW'(DATA_DEPTH - 1)) ? '0 : cp_q + DAW'(1);
						end
						bfs_pkg::OP_LEFT: begin
							cp_q <= (cp_q == '0) ? DAW'(DATA_DEPTH - 1) : cp_q - DAW'(1);
						end
						bfs_pkg::OP_OUT: begin
							emit_q <= 1'b1;
						end
						default: begin
							emit_q <= 1'b0;
						end
					endcase
					if (scan_ctl.start) begin
						if (scan_st.err) begin
							err_q   <= 1'b1;
							ip_q    <= len_q;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end else begin
						ip_q    <= ip_q + PW'(1);
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (scan_st.done) begin
						ip_q    <= scan_match;
						state_q <= S_DONE;
					end else if (scan_st.err) begin
						err_q   <= 1'b1;
						ip_q    <= len_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Step payload and emitted byte.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= step.value;
		end
		if (state_q == S_EXEC && op == bfs_pkg::OP_OUT) begin
			byte_q <= cell_cur;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (state_q == S_DONE) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			res_out_valid_q <= emit_q;
			res_byte_q      <= emit_q ? byte_q : 8'd0;
			res_halted_q    <= halted_now;
			res_bal_q       <= (bal_q == '0);
			res_err_q       <= err_q;
		end
	end

	assign result.valid             = res_vld_q;
	assign result.out_valid         = res_out_valid_q;
	assign result.out_byte          = res_byte_q;
	assign result.halted            = res_halted_q;
	assign result.brackets_balanced = res_bal_q;
	assign result.bracket_error     = res_err_q;

	// The instruction pointer never runs past the program end.
	a_ip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ip_q <= len_q)
		else $error("instruction pointer beyond program length");

	// The data pointer stays inside the cell memory.
	a_cp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cp_q <= DAW'(DATA_DEPTH - 1))
		else $error("data pointer beyond cell memory");

	// A finishing word always finds the result register empty.
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> !res_vld_q)
		else $error("result register still full at completion");

	// An output byte is only flagged by executing an output instruction.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(emit_q) |-> $past(state_q) == S_EXEC)
		else $error("output flag raised outside execution");

endmodule

@@ rtl/bfs_ram.sv @@
// ----------------------------------------------------------------------------
// bfs_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle. Contents have no reset.
// ----------------------------------------------------------------------------
module bfs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bfs_scan.sv @@
// ----------------------------------------------------------------------------
// bfs_scan: bracket matching scan unit
// Walks the program store one byte per cycle, forward or backward, keeping
// the nesting depth. The next position, the new depth and the bound check
// are formed combinationally on every step.
// ----------------------------------------------------------------------------
module bfs_scan #(
	parameter int unsigned PROG_DEPTH = bfs_pkg::PROG_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfs_pkg::scan_ctl_t            ctl,
	input  logic                          active,
	input  logic [$clog2(PROG_DEPTH+1)-1:0] ip,
	input  logic [$clog2(PROG_DEPTH+1)-1:0] len,
	input  logic [7:0]                    op,
	output bfs_pkg::scan_st_t             st,
	output logic [$clog2(PROG_DEPTH+1)-1:0] match,
	output logic [$clog2(PROG_DEPTH)-1:0] raddr
);

	localparam int unsigned PW  = $clog2(PROG_DEPTH + 1);
	localparam int unsigned PAW = $clog2(PROG_DEPTH);

	logic [PW-1:0] sp_q;
	logic [PW-1:0] depth_q;
	logic          back_q;

	logic          back;
	logic [PW-1:0] base;
	logic [PW-1:0] nxt;
	logic [PW-1:0] dn;
	logic          hit;
	logic          bound_err;

	always_comb begin
		back = ctl.start ? ctl.back : back_q;
		base = ctl.start ? ip : sp_q;
		nxt  = back ? base - PW'(1) : base + PW'(1);
		if (ctl.start) begin
			dn = PW'(1);
		end else if (op == (back ? bfs_pkg::OP_CLOSE : bfs_pkg::OP_OPEN)) begin
			dn = depth_q + PW'(1);
		end else if (op == (back ? bfs_pkg::OP_OPEN : bfs_pkg::OP_CLOSE)) begin
			dn = depth_q - PW'(1);
		end else begin
			dn = depth_q;
		end
		hit       = active && (dn == '0);
		// Backward checks the current position before stepping, forward checks
		// the new position against the program end.
		bound_err = back ? (base == '0) : (nxt >= len);
		st.done   = hit;
		st.err    = (ctl.start || active) && !hit && bound_err;
		match     = sp_q + PW'(1);
		raddr     = nxt[PAW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			depth_q <= '0;
			back_q  <= 1'b0;
		end else if (ctl.start || active) begin
			sp_q    <= nxt;
			depth_q <= dn;
			back_q  <= back;
		end
	end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the instruction stepper
// Loads short programs, steps through them one instruction per word, clears
// the data and the program store, and compares every result word with a
// behavioral copy of the machine that is kept in step with the input channel.
// ----------------------------------------------------------------------------
module tb;

	// The block is built at small depths. The data clear sweep stays short,
	// the cell pointer wraps after 256 moves, and a program of 64 bytes fills
	// the store.
	localparam int unsigned DATA_DEPTH   = 256;
	localparam int unsigned PROG_DEPTH   = 64;
	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned TARGET_STEPS = 600;
	localparam int unsigned SETTLE       = 50;

	// The fields of one result word, in the order of the result channel.
	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       halted;
		logic       balanced;
		logic       scan_err;
	} step_result_t;

	// The ways the receiver throttles the result channel.
	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_THIRD,
		RX_RUNS
	} rx_mode_t;

	// A copy of the machine state, advanced once for every accepted step
	// word, and the queue of result words that the block still owes.
	class machine_shadow;
		logic [7:0]   prog_mem [PROG_DEPTH];
		logic [7:0]   cell_mem [DATA_DEPTH];
		logic [12:0]  prog_len;
		logic [12:0]  instr_ptr;
		logic [12:0]  balance;
		logic [14:0]  cell_ptr;
		logic         scan_err;
		step_result_t results_due [$];
		int           results_seen;
		int           mismatches;

		function new();
			foreach (prog_mem[i]) prog_mem[i] = '0;
			foreach (cell_mem[i]) cell_mem[i] = '0;
			prog_len     = '0;
			instr_ptr    = '0;
			balance      = '0;
			cell_ptr     = '0;
			scan_err     = 1'b0;
			results_seen = 0;
			mismatches   = 0;
		endfunction

		function bit store_full();
			return prog_len >= PROG_DEPTH;
		endfunction

		function int pending();
			return results_due.size();
		endfunction

		// Executes the instruction under the instruction pointer.
		function void run_instruction(input logic [7:0] in_byte, output logic emitted,
			output logic [7:0] emit_byte);
			logic [7:0]  op;
			logic [12:0] walk;
			int          depth;
			emitted   = 1'b0;
			emit_byte = '0;
			if (instr_ptr >= prog_len)
				return;
			op   = prog_mem[instr_ptr];
			walk = instr_ptr;
			case (op)
			bfs_pkg::OP_RIGHT: cell_ptr = (cell_ptr == DATA_DEPTH - 1) ? '0 : cell_ptr + 1'b1;
			bfs_pkg::OP_LEFT: cell_ptr = (cell_ptr == 0) ? 15'(DATA_DEPTH - 1) : cell_ptr - 1'b1;
			bfs_pkg::OP_INC: cell_mem[cell_ptr] = cell_mem[cell_ptr] + 8'd1;
			bfs_pkg::OP_DEC: cell_mem[cell_ptr] = cell_mem[cell_ptr] - 8'd1;
			bfs_pkg::OP_OUT: begin
				emitted   = 1'b1;
				emit_byte = cell_mem[cell_ptr];
			end
			bfs_pkg::OP_IN: cell_mem[cell_ptr] = in_byte;
			bfs_pkg::OP_OPEN: begin
				if (cell_mem[cell_ptr] == 8'd0) begin
					depth = 1;
					while (depth != 0) begin
						walk++;
						if (walk >= prog_len) begin
							scan_err  = 1'b1;
							instr_ptr = prog_len;
							return;
						end
						if (prog_mem[walk] == bfs_pkg::OP_OPEN)
							depth++;
						else if (prog_mem[walk] == bfs_pkg::OP_CLOSE)
							depth--;
					end
				end
			end
			bfs_pkg::OP_CLOSE: begin
				if (cell_mem[cell_ptr] != 8'd0) begin
					depth = 1;
					while (depth != 0) begin
						if (walk == 0) begin
							scan_err  = 1'b1;
							instr_ptr = prog_len;
							return;
						end
						walk--;
						if (prog_mem[walk] == bfs_pkg::OP_OPEN)
							depth--;
						else if (prog_mem[walk] == bfs_pkg::OP_CLOSE)
							depth++;
					end
				end
			end
			default: ;
			endcase
			instr_ptr = walk + 1'b1;
		endfunction

		// Applies one accepted step word and queues the result it must yield.
		function void note_step(input logic [1:0] action, input logic [7:0] value);
			step_result_t expected;
			logic         emitted;
			logic [7:0]   emit_byte;
			emitted   = 1'b0;
			emit_byte = '0;
			case (action)
			bfs_pkg::ACT_LOAD: begin
				if (prog_len < PROG_DEPTH) begin
					prog_mem[prog_len] = value;
					prog_len++;
					if (value == bfs_pkg::OP_OPEN)
						balance++;
					else if (value == bfs_pkg::OP_CLOSE)
						balance--;
				end
			end
			bfs_pkg::ACT_EXEC: run_instruction(value, emitted, emit_byte);
			bfs_pkg::ACT_CLR_DATA: begin
				foreach (cell_mem[i]) cell_mem[i] = '0;
				cell_ptr  = '0;
				instr_ptr = '0;
				scan_err  = 1'b0;
			end
			bfs_pkg::ACT_CLR_PROG: begin
				prog_len  = '0;
				balance   = '0;
				instr_ptr = '0;
				scan_err  = 1'b0;
			end
			default: ;
			endcase
			expected.out_valid = emitted;
			expected.out_byte  = emit_byte;
			expected.halted    = instr_ptr >= prog_len;
			expected.balanced  = balance == 0;
			expected.scan_err  = scan_err;
			results_due.push_back(expected);
		endfunction

		task report(input string what);
			mismatches++;
			if (mismatches <= 40)
				$display("result word %0d: %s", results_seen, what);
		endtask

		task check_result(input step_result_t got);
			step_result_t want;
			if (results_due.size() == 0) begin
				report("arrived with no step word outstanding");
				results_seen++;
				return;
			end
			want = results_due.pop_front();
			if (got.out_valid !== want.out_valid)
				report($sformatf("out_valid %b, expected %b", got.out_valid, want.out_valid));
			if (got.out_byte !== want.out_byte)
				report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
			if (got.halted !== want.halted)
				report($sformatf("halted %b, expected %b", got.halted, want.halted));
			if (got.balanced !== want.balanced)
				report($sformatf("brackets_balanced %b, expected %b", got.balanced,
					want.balanced));
			if (got.scan_err !== want.scan_err)
				report($sformatf("bracket_error %b, expected %b", got.scan_err,
					want.scan_err));
			results_seen++;
		endtask
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	bfs_step_if    step_bus ();
	bfs_result_if  result_bus ();
	machine_shadow shadow;

	int steps_sent;
	int burst_left;
	int hold_req;
	int idle_cycles = 0;

	bf_instruction_stepper_core #(
		.DATA_DEPTH(DATA_DEPTH),
		.PROG_DEPTH(PROG_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step_bus),
		.result(result_bus)
	);

	always #5 clk = ~clk;

	// Every result word that leaves the block is checked at the rising edge
	// where it is taken, against the oldest word the shadow expects.
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			shadow.check_result(step_result_t'{result_bus.out_valid, result_bus.out_byte,
				result_bus.halted, result_bus.brackets_balanced, result_bus.bracket_error});
	end

	// Watchdog. The slowest correct stretch without any word moving is a data
	// clear sweep behind a long receiver hold-off, so a much longer silence means
	// the block is stuck.
	always @(posedge clk) begin
		if ((step_bus.valid && step_bus.ready) || (result_bus.valid && result_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// The receiver. It switches between throttling modes after randomly drawn
	// runs, so that stalls land on every phase of the block's work, and
	// it honors a hold-off request from the stimulus by keeping ready low
	// for the requested number of cycles, counted here.
	initial begin
		rx_mode_t rx_mode;
		int       mode_left;
		int       tick;
		int       held;
		result_bus.ready = 1'b0;
		rx_mode          = RX_FREE;
		mode_left        = 0;
		tick             = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				held     = hold_req;
				hold_req = 0;
				result_bus.ready <= 1'b0;
				repeat (held - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				tick++;
				case (rx_mode)
				RX_FREE: result_bus.ready <= 1'b1;
				RX_RANDOM: result_bus.ready <= ($urandom_range(0, 2) != 0);
				RX_THIRD: result_bus.ready <= (tick % 3 == 0);
				default: result_bus.ready <= ((tick / 8) % 2 == 0);
				endcase
			end
		end
	end

	// Drops valid and lets the given number of cycles pass. Called at a
	// falling edge, it returns at a falling edge.
	task automatic idle(input int cycles);
		step_bus.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Offers one step word and waits until the block takes it. The sender
	// works in bursts of random length; before each burst it may leave a
	// gap. Valid stays high on return, so back-to-back words keep it up.
	task automatic send_word(input logic [1:0] action, input logic [7:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0)
				idle(gap);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		step_bus.valid  <= 1'b1;
		step_bus.action <= action;
		step_bus.value  <= value;
		do
			@(posedge clk);
		while (!step_bus.ready);
		// A load into a full store is dropped by the block and is not counted.
		if (!(action == bfs_pkg::ACT_LOAD && shadow.store_full()))
			steps_sent++;
		shadow.note_step(action, value);
		@(negedge clk);
	endtask

	// Stops offering words until every result word has come back.
	task automatic drain();
		idle(1);
		while (shadow.pending() != 0)
			@(negedge clk);
	endtask

	// Runs the given number of execute words, each with a random input byte
	// for a comma instruction.
	task automatic run_steps(input int count);
		repeat (count) send_word(bfs_pkg::ACT_EXEC, 8'($urandom_range(0, 255)));
	endtask

	// Loads a random program. Most bytes are instructions; a few are random
	// bytes, mostly comments. Apart from those, a balanced program never closes a
	// bracket that is not open and gets its open brackets closed at the end; an
	// unbalanced one may close too early and leave brackets open.
	task automatic load_random_program(input int len, input bit unbalanced);
		int         open;
		int         pick;
		logic [7:0] code;
		open = 0;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				code = 8'($urandom_range(0, 255));
			end else if (pick < 20) begin
				code = bfs_pkg::OP_OPEN;
				open++;
			end else if (pick < 32 && (open > 0 || unbalanced)) begin
				code = bfs_pkg::OP_CLOSE;
				open--;
			end else begin
				case ($urandom_range(0, 7))
				0: code = bfs_pkg::OP_RIGHT;
				1: code = bfs_pkg::OP_LEFT;
				2, 3: code = bfs_pkg::OP_INC;
				4, 5: code = bfs_pkg::OP_DEC;
				6: code = bfs_pkg::OP_OUT;
				default: code = bfs_pkg::OP_IN;
				endcase
			end
			send_word(bfs_pkg::ACT_LOAD, code);
		end
		if (!unbalanced) begin
			while (open > 0) begin
				send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_CLOSE);
				open--;
			end
		end
	endtask

	initial begin
		int pick;
		int len;
		shadow          = new();
		arst_n          = 1'b0;
		step_bus.valid  = 1'b0;
		step_bus.action = bfs_pkg::ACT_LOAD;
		step_bus.value  = 8'h00;
		steps_sent      = 0;
		burst_left      = 0;
		hold_req        = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. An execute on an empty store must report halted.
		send_word(bfs_pkg::ACT_EXEC, 8'h00);

		// A program that touches every instruction: increment, decrement
		// through zero so the cell wraps to 255, output, a left move from
		// cell zero that wraps to the top cell, input, a right move that
		// wraps back to cell zero, and a bracket pair. The zero and all-ones
		// bytes are comments. Cell zero is nonzero when the brackets run, so
		// the close bracket jumps back just past its partner.
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_INC);
		send_word(bfs_pkg::ACT_LOAD, 8'h00);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_DEC);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_DEC);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_OUT);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_LEFT);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_IN);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_OUT);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_RIGHT);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_OPEN);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_CLOSE);
		send_word(bfs_pkg::ACT_LOAD, 8'hFF);
		repeat (11) send_word(bfs_pkg::ACT_EXEC, 8'hFF);

		// A lone close bracket over a nonzero cell scans back off the start
		// of the program, which flags the error and halts the machine. A
		// further execute on the halted machine changes nothing.
		send_word(bfs_pkg::ACT_CLR_PROG, 8'h00);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_CLOSE);
		send_word(bfs_pkg::ACT_EXEC, 8'h00);
		send_word(bfs_pkg::ACT_EXEC, 8'h00);

		// After a data clear the error is gone and every cell is zero, so an
		// open bracket with no partner scans forward off the end.
		send_word(bfs_pkg::ACT_CLR_DATA, 8'h00);
		send_word(bfs_pkg::ACT_LOAD, bfs_pkg::OP_OPEN);
		send_word(bfs_pkg::ACT_EXEC, 8'h00);
		send_word(bfs_pkg::ACT_EXEC, 8'h00);

		// Let everything come back, then hold the receiver off for a long
		// stretch while the sender keeps offering, so the block backs up
		// and stalls its input.
		drain();
		hold_req = 400;

		// Random part. Most of it is well-formed programs run for a while;
		// the rest is unbalanced programs, further steps of the program in
		// place, noise words, and programs that overrun the store.
		while (steps_sent < TARGET_STEPS) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				hold_req = $urandom_range(100, 400);
			else if (pick < 6)
				drain();

			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_word(bfs_pkg::ACT_CLR_PROG, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 4) == 0)
					send_word(bfs_pkg::ACT_CLR_DATA, 8'($urandom_range(0, 255)));
				len = $urandom_range(1, 16);
				load_random_program(len, 1'b0);
				run_steps($urandom_range(len, 4 * len));
			end else if (pick < 75) begin
				send_word(bfs_pkg::ACT_CLR_PROG, 8'($urandom_range(0, 255)));
				len = $urandom_range(1, 12);
				load_random_program(len, 1'b1);
				run_steps($urandom_range(len, 3 * len));
			end else if (pick < 85) begin
				run_steps($urandom_range(1, 20));
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 6))
					send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				// Loads past the end of the store must be dropped.
				send_word(bfs_pkg::ACT_CLR_PROG, 8'($urandom_range(0, 255)));
				load_random_program(PROG_DEPTH + 3, 1'b1);
				run_steps($urandom_range(1, 40));
			end
		end

		// Wait for the last result words, then give the block time to show
		// any stray word before the verdict.
		drain();
		repeat (SETTLE) @(negedge clk);
		if (shadow.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
